// ===== src/sensor_response_frame_checker_core_defines.svh =====
// Assertion macros for the frame checker.
`ifndef SENSOR_RESPONSE_FRAME_CHECKER_CORE_DEFINES_SVH
`define SENSOR_RESPONSE_FRAME_CHECKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SRFC_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define SRFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SRFC_ASSERT_NOW(label, cond, msg)
`define SRFC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== src/srfc_pkg.sv =====
package srfc_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  FUNC_CODE  = 8'h03;
  localparam logic [7:0]  BYTE_COUNT = 8'h04;

  typedef logic [2:0] pos_t;
  typedef logic [1:0] status_t;

  localparam pos_t POS_FUNC   = 3'd0;
  localparam pos_t POS_COUNT  = 3'd1;
  localparam pos_t POS_D0     = 3'd2;
  localparam pos_t POS_D1     = 3'd3;
  localparam pos_t POS_D2     = 3'd4;
  localparam pos_t POS_D3     = 3'd5;
  localparam pos_t POS_CRC_LO = 3'd6;
  localparam pos_t POS_CRC_HI = 3'd7;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FUNC  = 2'd1;
  localparam status_t ST_COUNT = 2'd2;
  localparam status_t ST_CRC   = 2'd3;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/srfc_in_if.sv =====
interface srfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== src/srfc_out_if.sv =====
interface srfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] reading;
  logic [1:0]  status;

  modport source (output valid, output reading, output status, input ready);
  modport sink (input valid, input reading, input status, output ready);
endinterface

// ===== src/sensor_response_frame_checker_core.sv =====
// Result: valid in the cycle after the request carrying byte 7 is taken.
// Throughput: one byte per cycle unless a pending result is not taken; the
// CRC byte update feeds the running CRC register ahead of the result compare.
// Reset (rst, synchronous): byte position 0, CRC 0xFFFF, frame state
// cleared, no result pending.
`include "sensor_response_frame_checker_core_defines.svh"

module sensor_response_frame_checker_core
  import srfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  srfc_in_if.sink    rx,
  srfc_out_if.source result
);

  pos_t        byte_position;
  logic [15:0] running_crc;
  logic [31:0] data_word;
  logic [7:0]  received_crc_low;
  status_t     header_error;

  logic        res_valid;
  logic [31:0] res_reading;
  status_t     res_status;

  logic        rx_fire;
  pos_t        pos;
  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic [15:0] rx_crc;
  status_t     status_next;

  assign rx.ready = !res_valid || result.ready;
  assign rx_fire  = rx.valid && rx.ready;
  assign pos      = rx.frame_start ? POS_FUNC : byte_position;

  assign crc_base = (pos == POS_FUNC) ? CRC_INIT : running_crc;
  assign crc_next = crc_byte(crc_base, rx.rx_byte);
  assign rx_crc   = {rx.rx_byte, received_crc_low};

  always_comb begin
    if (header_error != ST_OK) begin
      status_next = header_error;
    end else if (rx_crc != running_crc) begin
      status_next = ST_CRC;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= POS_FUNC;
      running_crc      <= CRC_INIT;
      data_word        <= '0;
      received_crc_low <= '0;
      header_error     <= ST_OK;
    end else if (rx_fire) begin
      byte_position <= pos + 3'd1;
      case (pos)
        POS_FUNC: begin
          running_crc      <= crc_next;
          data_word        <= '0;
          received_crc_low <= '0;
          header_error     <= (rx.rx_byte != FUNC_CODE) ? ST_FUNC : ST_OK;
        end
        POS_COUNT: begin
          running_crc <= crc_next;
          if (header_error == ST_OK && rx.rx_byte != BYTE_COUNT) begin
            header_error <= ST_COUNT;
          end
        end
        POS_D0, POS_D1, POS_D2, POS_D3: begin
          running_crc <= crc_next;
          data_word   <= {data_word[23:0], rx.rx_byte};
        end
        POS_CRC_LO: begin
          received_crc_low <= rx.rx_byte;
        end
        default: begin
          running_crc <= CRC_INIT;
        end
      endcase
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rx_fire && pos == POS_CRC_HI) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire && pos == POS_CRC_HI) begin
      res_status  <= status_next;
      res_reading <= (status_next == ST_OK) ? data_word : '1;
    end
  end

  assign result.valid   = res_valid;
  assign result.reading = res_reading;
  assign result.status  = res_status;

  `SRFC_ASSERT_NEXT(a_only_last_byte, rx_fire && pos != POS_CRC_HI && (!res_valid || result.ready), !res_valid, "result without last byte")
  `SRFC_ASSERT_NOW(a_err_all_ones, !(res_valid && res_status != ST_OK) || res_reading == 32'hFFFF_FFFF, "error result not all ones")
  `SRFC_ASSERT_NEXT(a_wrap_after_last, rx_fire && pos == POS_CRC_HI, byte_position == POS_FUNC && running_crc == CRC_INIT, "frame state not restarted")

endmodule

// ===== sim/sensor_response_frame_checker_core_tb.sv =====
module sensor_response_frame_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srfc_pkg::*;

  localparam int RANDOM_BYTES   = 1950;
  localparam int PHASE_BYTES    = RANDOM_BYTES / 3;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int QUIET_LIMIT    = 4000;
  localparam int TAIL_CYCLES    = 8;
  localparam int SRC_IDLE [3]   = '{17, 53, 0};
  localparam int RCV_IDLE [3]   = '{53, 17, 0};

  typedef struct packed {
    logic [31:0] rd;
    status_t     st;
  } frame_result_t;

  typedef struct packed {
    bit            typed;
    frame_result_t res;
  } row_note_t;

  typedef struct packed {
    logic [7:0]    b;
    logic          s;
    bit            typed;
    frame_result_t res;
  } dir_row_t;

  localparam frame_result_t NO_RES    = '{32'h0, ST_OK};
  localparam frame_result_t FUNC_RES  = '{32'hFFFF_FFFF, ST_FUNC};
  localparam frame_result_t COUNT_RES = '{32'hFFFF_FFFF, ST_COUNT};
  localparam int DIR_COUNT = 27;

  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b1, FUNC_RES},
    '{8'h03, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b1, COUNT_RES},
    '{8'h03, 1'b1, 1'b0, NO_RES}, '{8'h04, 1'b0, 1'b0, NO_RES},
    '{8'h12, 1'b0, 1'b0, NO_RES},
    '{8'h03, 1'b1, 1'b0, NO_RES}, '{8'h04, 1'b0, 1'b0, NO_RES},
    '{8'hDE, 1'b0, 1'b0, NO_RES}, '{8'hAD, 1'b0, 1'b0, NO_RES},
    '{8'hBE, 1'b0, 1'b0, NO_RES}, '{8'hEF, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst;

  srfc_in_if  rx_ch ();
  srfc_out_if res_ch ();

  sensor_response_frame_checker_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pos_t        trk_pos;
  logic [15:0] trk_crc;
  logic [31:0] trk_word;
  logic [7:0]  trk_crc_lo;
  status_t     trk_hdr;

  frame_result_t expected_frames [$];
  row_note_t     row_notes [$];

  int  src_idle;
  int  rcv_idle;
  bit  squeeze_req;
  int  bytes_sent;
  int  bytes_taken;
  int  quiet_cycles;
  int  fail_count;
  int  status_seen [4];

  function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ({1'b0, c[15:1]} ^ CRC_POLY) : {1'b0, c[15:1]};
    return c;
  endfunction

  function automatic bit frame_track(input logic [7:0] b, input logic s,
                                     output frame_result_t res);
    pos_t p;
    p = s ? POS_FUNC : trk_pos;
    res = NO_RES;
    case (p)
      POS_FUNC: begin
        trk_crc    = CRC_INIT;
        trk_word   = '0;
        trk_crc_lo = '0;
        trk_hdr    = (b != FUNC_CODE) ? ST_FUNC : ST_OK;
      end
      POS_COUNT: begin
        if (trk_hdr == ST_OK && b != BYTE_COUNT) trk_hdr = ST_COUNT;
      end
      POS_CRC_LO: trk_crc_lo = b;
      POS_CRC_HI: ;
      default: trk_word = {trk_word[23:0], b};
    endcase
    if (p < POS_CRC_LO) trk_crc = modbus_crc_step(trk_crc, b);
    trk_pos = p + 3'd1;
    if (p != POS_CRC_HI) return 1'b0;
    if (trk_hdr != ST_OK) res.st = trk_hdr;
    else if ({b, trk_crc_lo} != trk_crc) res.st = ST_CRC;
    res.rd = (res.st == ST_OK) ? trk_word : 32'hFFFF_FFFF;
    trk_crc = CRC_INIT;
    return 1'b1;
  endfunction

  task automatic offer_byte(input logic [7:0] b, input logic s, input bit typed,
                            input frame_result_t res);
    while ($urandom_range(99) < src_idle) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    row_notes.push_back('{typed, res});
    rx_ch.valid       <= 1'b1;
    rx_ch.rx_byte     <= b;
    rx_ch.frame_start <= s;
    bytes_sent++;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_frame();
    logic [7:0]  fr [8];
    logic [15:0] c;
    int          kind;
    int          len;
    bit          lead;
    kind = $urandom_range(99);
    lead = ($urandom_range(99) < 85);
    if (kind >= 96) begin
      len = $urandom_range(12, 1);
      repeat (len) offer_byte(8'($urandom), ($urandom_range(99) < 20), 1'b0, NO_RES);
    end else begin
      fr[0] = FUNC_CODE;
      fr[1] = BYTE_COUNT;
      for (int i = 2; i < 6; i++) fr[i] = 8'($urandom);
      if (kind >= 60 && kind < 70) begin
        fr[0] = 8'($urandom);
        if ($urandom_range(1) == 1) fr[1] = 8'($urandom);
      end else if (kind >= 70 && kind < 80) begin
        fr[1] = 8'($urandom);
      end
      c = CRC_INIT;
      for (int i = 0; i < 6; i++) c = modbus_crc_step(c, fr[i]);
      fr[6] = c[7:0];
      fr[7] = c[15:8];
      if (kind >= 80 && kind < 90) fr[6 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
      len = (kind >= 90) ? $urandom_range(7, 1) : 8;
      for (int i = 0; i < len; i++) offer_byte(fr[i], (i == 0) && lead, 1'b0, NO_RES);
    end
  endtask

  always @(posedge clk) begin : monitor
    row_note_t     note;
    frame_result_t pred;
    frame_result_t seen;
    if (!rst) begin
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (rx_ch.valid && rx_ch.ready) begin
        bytes_taken++;
        note = row_notes.pop_front();
        if (frame_track(rx_ch.rx_byte, rx_ch.frame_start, pred))
          expected_frames.push_back(note.typed ? note.res : pred);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_frames.size() == 0) begin
          $error("unexpected result: reading %h status %0d", res_ch.reading, res_ch.status);
          fail_count++;
        end else begin
          seen = expected_frames.pop_front();
          status_seen[seen.st]++;
          if (res_ch.reading !== seen.rd) begin
            $error("reading: expected %h, got %h", seen.rd, res_ch.reading);
            fail_count++;
          end
          if (res_ch.status !== seen.st) begin
            $error("status: expected %0d, got %0d", seen.st, res_ch.status);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : receiver
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end
      res_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("stalled for %0d cycles with %0d results outstanding",
             QUIET_LIMIT, expected_frames.size());
    $display("sensor_response_frame_checker_core_tb: errors");
    $finish;
  end

  initial begin : stimulus
    rst               = 1'b1;
    rx_ch.valid       = 1'b0;
    rx_ch.rx_byte     = 8'h00;
    rx_ch.frame_start = 1'b0;
    squeeze_req       = 1'b0;
    src_idle          = SRC_IDLE[0];
    rcv_idle          = RCV_IDLE[0];
    bytes_sent        = 0;
    bytes_taken       = 0;
    quiet_cycles      = 0;
    fail_count        = 0;
    status_seen       = '{0, 0, 0, 0};
    trk_pos           = POS_FUNC;
    trk_crc           = CRC_INIT;
    trk_word          = '0;
    trk_crc_lo        = '0;
    trk_hdr           = ST_OK;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_COUNT; i++)
      offer_byte(DIR_ROWS[i].b, DIR_ROWS[i].s, DIR_ROWS[i].typed, DIR_ROWS[i].res);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = SRC_IDLE[ph];
      rcv_idle = RCV_IDLE[ph];
      if (ph == 0) squeeze_req = 1'b1;
      while (bytes_sent < DIR_COUNT + (ph + 1) * PHASE_BYTES) send_random_frame();
    end

    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d bytes sent through three backpressure phases and one long hold-off",
             bytes_taken);
    $display("frames checked: ok %0d, bad function %0d, bad count %0d, crc mismatch %0d",
             status_seen[ST_OK], status_seen[ST_FUNC], status_seen[ST_COUNT],
             status_seen[ST_CRC]);
    if (fail_count == 0) begin
      $display("sensor_response_frame_checker_core_tb: clean");
    end else begin
      $display("sensor_response_frame_checker_core_tb: errors");
    end
    $finish;
  end

endmodule
